[rtl/core/isqe_pkg.sv]
// Package for the inventory skewed quote engine: request and response structs,
// register indexes, id constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isqe_pkg;
   localparam int INSTRUMENT_COUNT = 256;
   localparam int INST_AW = (INSTRUMENT_COUNT > 1) ? $clog2(INSTRUMENT_COUNT) : 1;

   localparam logic [1:0] REG_SPREAD      = 2'd0;
   localparam logic [1:0] REG_SKEW_FACTOR = 2'd1;
   localparam logic [1:0] REG_MAX_INV     = 2'd2;
   localparam logic [1:0] REG_QUOTE_SIZE  = 2'd3;

   localparam logic       ACT_BOOK = 1'b0;
   localparam logic       ACT_FILL = 1'b1;
   localparam logic       KIND_SEND   = 1'b0;
   localparam logic       KIND_CANCEL = 1'b1;
   localparam logic       SIDE_BID = 1'b0;
   localparam logic       SIDE_ASK = 1'b1;

   localparam logic [63:0] ID_SENTINEL = 64'd1000000000;
   localparam logic [63:0] BID_ID_BASE = 64'h4000_0000_0000_0000;
   localparam logic [63:0] ASK_ID_BASE = 64'h8000_0000_0000_0000;
   localparam logic [31:0] ID_STRIDE   = 32'd1000000;

   typedef struct packed {
      logic        action;
      logic [7:0]  instrument;
      logic [31:0] best_bid;
      logic [31:0] best_ask;
      logic        bid_present;
      logic        ask_present;
      logic [63:0] timestamp;
      logic        fill_side;
      logic [31:0] fill_qty;
      logic [63:0] fill_order;
   } req_type;

   typedef struct packed {
      logic        request_kind;
      logic        side;
      logic [7:0]  instrument_out;
      logic [63:0] ord_ref;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [63:0] time_out;
      logic        last;
   } rsp_type;

   // one per-instrument entry, kept in a single memory word
   typedef struct packed {
      logic [31:0] position;
      logic [63:0] bid_id;
      logic [63:0] ask_id;
      logic [31:0] last_bid;
      logic [31:0] last_ask;
      logic        bid_active;
      logic        ask_active;
      logic        initialized;
   } entry_type;
endpackage
`default_nettype wire

[rtl/core/inventory_skewed_quote_engine.sv]
// Top level of the inventory skewed quote engine; state memory, sequencer,
// output queue. Depends on isqe_pkg.
//
// channel | dir | handshake     | payload
// req     | in  | valid/stall   | isqe_pkg::req_type
// rsp     | out | valid/stall   | isqe_pkg::rsp_type
// csr     | in  | valid/ready   | 2-bit index, 32-bit data
//
// From acceptance to its responses entering the queue a request passes through
// memory read, skew multiply, target, clamp, emit with write back; fills use the
// same path. The sequence is set by the registered state memory read and the
// multiply. After reset a clearing pass writes every entry before requests are
// taken. Responses drain from a 4-deep queue; a new request is taken only once
// the engine is idle and the queue is empty.
`timescale 1ns / 1ps
`default_nettype none
module inventory_skewed_quote_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  isqe_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output isqe_pkg::rsp_type     rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [1:0]            csr_index,
   input  wire  [31:0]           csr_data
);
   import isqe_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0, ST_IDLE = 3'd1, ST_READ = 3'd2,
                          ST_MUL = 3'd3, ST_TGT = 3'd4, ST_CLAMP = 3'd5, ST_EMIT = 3'd6;

   // configuration
   logic [19:0] hspread_ff;
   logic signed [31:0] skew_factor_ff;
   logic [30:0] max_inv_ff;
   logic [31:0] quote_size_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         hspread_ff <= 20'd1; skew_factor_ff <= '0;
         max_inv_ff <= 31'd100; quote_size_ff <= 32'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SPREAD:      hspread_ff <= csr_data[19:0];
            REG_SKEW_FACTOR: skew_factor_ff <= csr_data;
            REG_MAX_INV:     max_inv_ff <= csr_data[30:0];
            REG_QUOTE_SIZE:  quote_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // state memory
   entry_type mem [INSTRUMENT_COUNT];
   entry_type rd_ff;
   logic we;
   logic [INST_AW-1:0] waddr, raddr;
   entry_type wdata;
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [2:0] state_ff, state_in;
   logic [INST_AW:0] clr_ff;
   req_type r_ff;
   logic in_range_ff;
   logic signed [63:0] prod_ff;
   logic signed [33:0] tb_ff, ta_ff;
   logic [31:0] tbc_ff, tac_ff;
   logic signed [31:0] skew_c;

   // output queue
   rsp_type q_ff [4];
   logic [2:0] qcnt_ff;
   logic [1:0] qhead_ff;

   assign req_stall = !(state_ff == ST_IDLE && qcnt_ff == 3'd0);
   wire take = req_valid && !req_stall;
   // read the incoming entry while idle, then hold the accepted one
   assign raddr = (state_ff == ST_IDLE) ? req_data.instrument[INST_AW-1:0]
                                        : r_ff.instrument[INST_AW-1:0];

   // skew rounding, half away from zero, saturated
   logic [63:0] mag;
   logic [48:0] rmag;
   always_comb begin
      mag = prod_ff[63] ? (64'd0 - prod_ff) : prod_ff;
      rmag = 49'((mag + 64'd32768) >> 16);
      if (rmag > 49'd2147483647)
         skew_c = prod_ff[63] ? ((rmag > 49'd2147483648) ? 32'sh8000_0000 : 32'sh8000_0000)
                              : 32'sh7fff_ffff;
      else
         skew_c = prod_ff[63] ? -$signed(rmag[31:0]) : $signed(rmag[31:0]);
   end

   entry_type e;
   logic signed [33:0] mid, hs, sk, tb, ta;
   logic signed [33:0] newpos;
   rsp_type pend [4];
   logic [3:0] pv;
   logic [63:0] bid_id, ask_id;
   logic [63:0] base_off;
   logic signed [32:0] pos33, mx;
   logic book_ok;

   always_comb begin
      state_in = state_ff; we = 1'b0; waddr = r_ff.instrument[INST_AW-1:0];
      wdata = rd_ff; e = rd_ff; pv = '0;
      for (int k = 0; k < 4; k++) pend[k] = '0;
      mid = 34'(({2'b0, r_ff.best_bid} + {2'b0, r_ff.best_ask}) >>> 1);
      hs = 34'(hspread_ff);
      sk = 34'(skew_c);
      tb = (mid > hs + sk) ? mid - hs - sk : 34'sd1;
      ta = mid + hs - sk;
      if (ta <= tb) ta = tb + 34'sd1;
      newpos = '0; bid_id = '0; ask_id = '0;
      base_off = 64'(r_ff.instrument) * 64'(ID_STRIDE);
      pos33 = 33'($signed(rd_ff.position)); mx = 33'(max_inv_ff);
      book_ok = r_ff.bid_present && r_ff.ask_present && (r_ff.best_bid < r_ff.best_ask);
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1; waddr = clr_ff[INST_AW-1:0]; wdata = '0;
            wdata.bid_id = ID_SENTINEL; wdata.ask_id = ID_SENTINEL;
            if (clr_ff == (INST_AW+1)'(INSTRUMENT_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (take) state_in = ST_READ;
         ST_READ: state_in = in_range_ff ? ST_MUL : ST_IDLE;
         ST_MUL:  state_in = ST_TGT;
         ST_TGT:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_EMIT;
         ST_EMIT: begin
            state_in = ST_IDLE;
            if (r_ff.action == ACT_FILL) begin
               we = 1'b1;
               newpos = (r_ff.fill_side == SIDE_BID) ?
                        34'($signed(rd_ff.position)) + 34'(r_ff.fill_qty) :
                        34'($signed(rd_ff.position)) - 34'(r_ff.fill_qty);
               if (newpos > 34'sh7fff_ffff) e.position = 32'h7fff_ffff;
               else if (newpos < -34'sh8000_0000) e.position = 32'h8000_0000;
               else e.position = newpos[31:0];
               if (r_ff.fill_side == SIDE_BID && r_ff.fill_order == rd_ff.bid_id)
                  e.bid_active = 1'b0;
               if (r_ff.fill_side == SIDE_ASK && r_ff.fill_order == rd_ff.ask_id)
                  e.ask_active = 1'b0;
               wdata = e;
            end else if (book_ok) begin
               we = 1'b1;
               bid_id = rd_ff.bid_id; ask_id = rd_ff.ask_id;
               if (bid_id == ID_SENTINEL) begin
                  bid_id = BID_ID_BASE + base_off; ask_id = ASK_ID_BASE + base_off;
               end
               for (int k = 0; k < 4; k++) begin
                  pend[k].instrument_out = r_ff.instrument;
                  pend[k].time_out = r_ff.timestamp;
               end
               pend[0].request_kind = KIND_CANCEL; pend[0].side = SIDE_BID;
               pend[1].request_kind = KIND_SEND;   pend[1].side = SIDE_BID;
               pend[2].request_kind = KIND_CANCEL; pend[2].side = SIDE_ASK;
               pend[3].request_kind = KIND_SEND;   pend[3].side = SIDE_ASK;
               // bid side
               if (pos33 < mx) begin
                  if (!rd_ff.bid_active || tbc_ff != rd_ff.last_bid) begin
                     if (rd_ff.bid_active) begin
                        pv[0] = 1'b1; pend[0].ord_ref = bid_id; bid_id = bid_id + 64'd1;
                     end
                     pv[1] = 1'b1; pend[1].ord_ref = bid_id;
                     pend[1].price = tbc_ff; pend[1].quantity = quote_size_ff;
                     e.last_bid = tbc_ff; e.bid_active = 1'b1;
                  end
               end else if (rd_ff.bid_active) begin
                  pv[0] = 1'b1; pend[0].ord_ref = bid_id; e.bid_active = 1'b0;
               end
               // ask side
               if (pos33 > -mx) begin
                  if (!rd_ff.ask_active || tac_ff != rd_ff.last_ask) begin
                     if (rd_ff.ask_active) begin
                        pv[2] = 1'b1; pend[2].ord_ref = ask_id; ask_id = ask_id + 64'd1;
                     end
                     pv[3] = 1'b1; pend[3].ord_ref = ask_id;
                     pend[3].price = tac_ff; pend[3].quantity = quote_size_ff;
                     e.last_ask = tac_ff; e.ask_active = 1'b1;
                  end
               end else if (rd_ff.ask_active) begin
                  pv[2] = 1'b1; pend[2].ord_ref = ask_id; e.ask_active = 1'b0;
               end
               e.bid_id = bid_id; e.ask_id = ask_id;
               wdata = e;
               priority if (pv[3]) pend[3].last = 1'b1;
               else if (pv[2]) pend[2].last = 1'b1;
               else if (pv[1]) pend[1].last = 1'b1;
               else if (pv[0]) pend[0].last = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // queue push packs valid entries in order; only pushed when empty
   logic [2:0] cnt_push;
   rsp_type packed_q [4];
   always_comb begin
      cnt_push = '0;
      for (int k = 0; k < 4; k++) packed_q[k] = '0;
      for (int k = 0; k < 4; k++)
         if (pv[k]) begin
            packed_q[cnt_push[1:0]] = pend[k];
            cnt_push = cnt_push + 3'd1;
         end
   end

   wire pop = rsp_valid && !rsp_stall;
   assign rsp_valid = qcnt_ff != 3'd0;
   assign rsp_data = q_ff[qhead_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; qcnt_ff <= '0; qhead_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_EMIT && cnt_push != 3'd0) begin
            qcnt_ff <= cnt_push; qhead_ff <= '0;
         end else if (pop) begin
            qcnt_ff <= qcnt_ff - 3'd1; qhead_ff <= qhead_ff + 2'd1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (take) begin
         r_ff <= req_data;
         in_range_ff <= 32'(req_data.instrument) < INSTRUMENT_COUNT;
      end
      if (state_ff == ST_MUL) prod_ff <= $signed(rd_ff.position) * skew_factor_ff;
      if (state_ff == ST_TGT) begin tb_ff <= tb; ta_ff <= ta; end
      if (state_ff == ST_CLAMP) begin
         tbc_ff <= tb_ff < 0 ? 32'd0 : (tb_ff > 34'shffff_ffff ? 32'hffff_ffff : tb_ff[31:0]);
         tac_ff <= ta_ff < 0 ? 32'd0 : (ta_ff > 34'shffff_ffff ? 32'hffff_ffff : ta_ff[31:0]);
      end
      if (state_ff == ST_EMIT && cnt_push != 3'd0)
         for (int k = 0; k < 4; k++) q_ff[k] <= packed_q[k];
   end

`ifndef SYNTHESIS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |-> qcnt_ff == 3'd0) else $error("request taken with queue busy");
   a_emit_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> qcnt_ff == 3'd0) else $error("queue not empty at emit");
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= 3'd4) else $error("queue overflow");
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall) else $error("request during clear");
`endif
endmodule
`default_nettype wire

[tb/inventory_skewed_quote_engine_checker.sv]
// Checker for the inventory skewed quote engine: tracks per-instrument state,
// predicts the cancel/send requests and compares them. Depends on isqe_pkg.
`timescale 1ns / 1ps
module inventory_skewed_quote_engine_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_stall,
   input  isqe_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_stall,
   input  isqe_pkg::rsp_type  rsp_data,
   input  wire                csr_valid,
   input  wire                csr_ready,
   input  wire  [1:0]         csr_index,
   input  wire  [31:0]        csr_data,
   output int                 errors,
   output int                 pending,
   output int                 events_seen,
   output int                 quotes_seen
);
   import isqe_pkg::*;

   // shadow of the per-instrument book state
   int          inventory [INSTRUMENT_COUNT];
   logic [63:0] bid_id    [INSTRUMENT_COUNT];
   logic [63:0] ask_id    [INSTRUMENT_COUNT];
   logic [31:0] bid_px    [INSTRUMENT_COUNT];
   logic [31:0] ask_px    [INSTRUMENT_COUNT];
   bit          bid_live  [INSTRUMENT_COUNT];
   bit          ask_live  [INSTRUMENT_COUNT];

   // shadow of the registers
   int unsigned hspread;
   int          skew_q16;
   longint      max_inv;
   logic [31:0] lot_qty;

   rsp_type quotes_due [$];

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp_px(longint v);
      if (v < 0) return 0;
      if (v > 64'sh0_FFFF_FFFF) return 64'sh0_FFFF_FFFF;
      return v;
   endfunction

   // inventory * factor / 2^16, rounded half away from zero
   function automatic longint inventory_skew(int inv);
      longint      prod;
      logic [63:0] mag;
      longint      rounded;
      prod = longint'(inv) * longint'(skew_q16);
      mag = (prod < 0) ? -prod : prod;
      rounded = longint'((mag + 64'd32768) >> 16);
      return sat32((prod < 0) ? -rounded : rounded);
   endfunction

   function automatic void queue_quote(logic kind, logic side, logic [7:0] k,
                                       logic [63:0] id, logic [31:0] px,
                                       logic [31:0] qty, logic [63:0] ts);
      rsp_type r;
      r.request_kind = kind;
      r.side = side;
      r.instrument_out = k;
      r.ord_ref = id;
      r.price = px;
      r.quantity = qty;
      r.time_out = ts;
      r.last = 1'b0;
      quotes_due.push_back(r);
   endfunction

   function automatic void apply_fill(req_type r);
      int k = r.instrument;
      if (r.fill_side == SIDE_BID) begin
         inventory[k] = int'(sat32(longint'(inventory[k]) + longint'(r.fill_qty)));
         if (r.fill_order == bid_id[k]) bid_live[k] = 0;
      end else begin
         inventory[k] = int'(sat32(longint'(inventory[k]) - longint'(r.fill_qty)));
         if (r.fill_order == ask_id[k]) ask_live[k] = 0;
      end
   endfunction

   // requote both sides of one instrument from a book update
   function automatic void predict_quotes(req_type r);
      int     k = r.instrument;
      int     n = 0;
      longint mid, sk, tb, ta, inv;
      if (!r.bid_present || !r.ask_present || r.best_bid >= r.best_ask) return;
      if (bid_id[k] == ID_SENTINEL) begin
         bid_id[k] = BID_ID_BASE + 64'(k) * 64'(ID_STRIDE);
         ask_id[k] = ASK_ID_BASE + 64'(k) * 64'(ID_STRIDE);
      end
      inv = inventory[k];
      mid = (longint'(r.best_bid) + longint'(r.best_ask)) / 2;
      sk = inventory_skew(inventory[k]);
      tb = (mid > longint'(hspread) + sk) ? mid - longint'(hspread) - sk : 1;
      ta = mid + longint'(hspread) - sk;
      if (ta <= tb) ta = tb + 1;
      tb = clamp_px(tb);
      ta = clamp_px(ta);

      if (inv < max_inv) begin
         if (!bid_live[k] || tb[31:0] != bid_px[k]) begin
            if (bid_live[k]) begin
               queue_quote(KIND_CANCEL, SIDE_BID, k, bid_id[k], 0, 0, r.timestamp);
               bid_id[k] = bid_id[k] + 1;
               n++;
            end
            queue_quote(KIND_SEND, SIDE_BID, k, bid_id[k], tb[31:0], lot_qty,
                        r.timestamp);
            n++;
            bid_px[k] = tb[31:0];
            bid_live[k] = 1;
         end
      end else if (bid_live[k]) begin
         queue_quote(KIND_CANCEL, SIDE_BID, k, bid_id[k], 0, 0, r.timestamp);
         n++;
         bid_live[k] = 0;
      end

      if (inv > -max_inv) begin
         if (!ask_live[k] || ta[31:0] != ask_px[k]) begin
            if (ask_live[k]) begin
               queue_quote(KIND_CANCEL, SIDE_ASK, k, ask_id[k], 0, 0, r.timestamp);
               ask_id[k] = ask_id[k] + 1;
               n++;
            end
            queue_quote(KIND_SEND, SIDE_ASK, k, ask_id[k], ta[31:0], lot_qty,
                        r.timestamp);
            n++;
            ask_px[k] = ta[31:0];
            ask_live[k] = 1;
         end
      end else if (ask_live[k]) begin
         queue_quote(KIND_CANCEL, SIDE_ASK, k, ask_id[k], 0, 0, r.timestamp);
         n++;
         ask_live[k] = 0;
      end

      if (n > 0) quotes_due[quotes_due.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_q;
      string   diff;
      if (reset) begin
         for (int i = 0; i < INSTRUMENT_COUNT; i++) begin
            inventory[i] = 0;
            bid_id[i] = ID_SENTINEL;
            ask_id[i] = ID_SENTINEL;
            bid_px[i] = '0;
            ask_px[i] = '0;
            bid_live[i] = 0;
            ask_live[i] = 0;
         end
         hspread = 1;
         skew_q16 = 0;
         max_inv = 100;
         lot_qty = 1;
         quotes_due.delete();
         errors = 0;
         events_seen = 0;
         quotes_seen = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SPREAD:      hspread = csr_data[19:0];
               REG_SKEW_FACTOR: skew_q16 = int'(csr_data);
               REG_MAX_INV:     max_inv = longint'(csr_data[30:0]);
               REG_QUOTE_SIZE:  lot_qty = csr_data;
               default: ;
            endcase
         end
         // accepted market events
         if (req_valid && !req_stall) begin
            events_seen++;
            if (req_data.instrument < INSTRUMENT_COUNT) begin
               if (req_data.action == ACT_FILL) apply_fill(req_data);
               else predict_quotes(req_data);
            end
         end
         // outgoing order requests
         if (rsp_valid && !rsp_stall) begin
            quotes_seen++;
            if (quotes_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: unexpected request %h", rsp_data);
            end else begin
               exp_q = quotes_due.pop_front();
               diff = "";
               if (rsp_data.request_kind !== exp_q.request_kind) diff = {diff, " kind"};
               if (rsp_data.side !== exp_q.side) diff = {diff, " side"};
               if (rsp_data.instrument_out !== exp_q.instrument_out)
                  diff = {diff, " instrument"};
               if (rsp_data.ord_ref !== exp_q.ord_ref) diff = {diff, " ord_ref"};
               if (rsp_data.price !== exp_q.price) diff = {diff, " price"};
               if (rsp_data.quantity !== exp_q.quantity) diff = {diff, " quantity"};
               if (rsp_data.time_out !== exp_q.time_out) diff = {diff, " time"};
               if (rsp_data.last !== exp_q.last) diff = {diff, " last"};
               if (diff != "") begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch in%s: expected %h got %h", diff, exp_q, rsp_data);
               end
            end
         end
      end
      pending = quotes_due.size();
   end
endmodule

[tb/inventory_skewed_quote_engine_tb.sv]
// Testbench top for the inventory skewed quote engine: clock, reset, stimulus
// and verdict. Depends on isqe_pkg, the quote engine and its checker.
`timescale 1ns / 1ps
module inventory_skewed_quote_engine_tb;
   import isqe_pkg::*;

   localparam int PHASE_EVENTS = 87;
   localparam int IDLE_LIMIT = 4000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_SPREAD;
   logic [31:0] csr_data = '0;

   int errors, pending, events_seen, quotes_seen;
   int burst_left = 4;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_hold = 0;
   int mode_left = 0;

   always #5 clock = ~clock;

   inventory_skewed_quote_engine DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   inventory_skewed_quote_engine_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending),
      .events_seen(events_seen), .quotes_seen(quotes_seen)
   );

   // receiver stall: stretches of none, random, and held stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(20, 80);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         default: begin
            if (stall_hold > 0) stall_hold <= stall_hold - 1;
            else stall_hold <= $urandom_range(0, 6);
            rsp_stall <= (stall_hold > 2);
         end
      endcase
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress, %0d requests still due", pending);
         $display("[inventory_skewed_quote_engine] ERROR");
         $finish;
      end
   end

   // one register write; the caller drops valid after the last one
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_regs(logic [31:0] hs, logic [31:0] sk, logic [31:0] mi,
                           logic [31:0] qs);
      write_reg(REG_SPREAD, hs);
      write_reg(REG_SKEW_FACTOR, sk);
      write_reg(REG_MAX_INV, mi);
      write_reg(REG_QUOTE_SIZE, qs);
      csr_valid <= 1'b0;
   endtask

   // present one event, hold it until taken, then maybe pause the burst
   task automatic send_event(req_type ev);
      req_valid <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type book(logic [7:0] k, logic [31:0] bb, logic [31:0] ba,
                                    logic bp, logic ap);
      req_type      ev;
      logic [287:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      ev = raw[$bits(req_type)-1:0];
      ev.action = ACT_BOOK;
      ev.instrument = k;
      ev.best_bid = bb;
      ev.best_ask = ba;
      ev.bid_present = bp;
      ev.ask_present = ap;
      return ev;
   endfunction

   function automatic req_type fill(logic [7:0] k, logic side, logic [31:0] qty,
                                    logic [63:0] oid);
      req_type ev;
      ev = book(k, $urandom, $urandom, 1'($urandom), 1'($urandom));
      ev.action = ACT_FILL;
      ev.fill_side = side;
      ev.fill_qty = qty;
      ev.fill_order = oid;
      return ev;
   endfunction

   function automatic logic [63:0] likely_id(logic [7:0] k, logic side);
      logic [63:0] base;
      base = (side == SIDE_BID) ? BID_ID_BASE : ASK_ID_BASE;
      return base + 64'(k) * 64'(ID_STRIDE) + 64'($urandom_range(0, 4));
   endfunction

   // mostly well-formed books and fills on a few busy instruments, some noise
   function automatic req_type random_event();
      logic [7:0]  k;
      logic [31:0] bb;
      int          pick;
      k = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         if ($urandom_range(0, 4) == 0)
            return fill(k, 1'($urandom), $urandom, {$urandom, $urandom});
         if ($urandom_range(0, 2) == 0)
            return fill(k, 1'($urandom), $urandom_range(0, 60), {$urandom, $urandom});
         pick = $urandom_range(0, 1);
         return fill(k, pick[0], $urandom_range(0, 60), likely_id(k, pick[0]));
      end
      if (pick < 37) return book(k, $urandom, $urandom, 1'($urandom), 1'($urandom));
      if (pick < 45) begin
         bb = 32'hFFFF_FFFF - $urandom_range(1, 40);
         if ($urandom_range(0, 1)) bb = $urandom_range(0, 5);
         return book(k, bb, bb + $urandom_range(1, 30), 1'b1, 1'b1);
      end
      if (pick < 52) begin
         bb = $urandom;
         return book(k, bb, bb + $urandom_range(1, 1000), 1'b1, 1'b1);
      end
      bb = 1000 + $urandom_range(0, 6);
      return book(k, bb, bb + $urandom_range(1, 6), 1'b1, 1'b1);
   endfunction

   initial begin
      logic [63:0] bid5, ask5;
      logic [31:0] regs [4][4];
      bid5 = BID_ID_BASE + 64'd5 * 64'(ID_STRIDE);
      ask5 = ASK_ID_BASE + 64'd5 * 64'(ID_STRIDE);
      regs[0] = '{32'd3, 32'h0000_8000, 32'd1000, 32'd10};
      regs[1] = '{32'd0, 32'h8000_0000, 32'd0, 32'd0};
      regs[2] = '{32'hF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      regs[3] = '{32'd20, 32'hFFFF_0000, 32'd50, 32'd7};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored books, quoting, requote, limits, saturation, price edges
      send_event(book(5, 100, 110, 1'b0, 1'b1));
      send_event(book(5, 100, 110, 1'b1, 1'b0));
      send_event(book(5, 110, 110, 1'b1, 1'b1));
      send_event(book(5, 120, 110, 1'b1, 1'b1));
      send_event(book(5, 100, 110, 1'b1, 1'b1));
      send_event(book(5, 100, 110, 1'b1, 1'b1));
      send_event(book(5, 102, 114, 1'b1, 1'b1));
      send_event(fill(5, SIDE_BID, 200, bid5 + 1));
      send_event(book(5, 102, 114, 1'b1, 1'b1));
      send_event(book(5, 104, 116, 1'b1, 1'b1));
      send_event(fill(5, SIDE_ASK, 400, ask5 + 1));
      send_event(book(5, 104, 116, 1'b1, 1'b1));
      send_event(fill(5, SIDE_BID, 32'hFFFF_FFFF, 64'd0));
      send_event(fill(5, SIDE_BID, 32'hFFFF_FFFF, {64{1'b1}}));
      send_event(book(5, 104, 116, 1'b1, 1'b1));
      send_event(fill(5, SIDE_ASK, 32'hFFFF_FFFF, 64'd0));
      send_event(fill(5, SIDE_ASK, 32'hFFFF_FFFF, 64'd0));
      send_event(fill(5, SIDE_ASK, 32'hFFFF_FFFF, 64'd0));
      send_event(book(5, 104, 116, 1'b1, 1'b1));
      send_event(book(0, 0, 1, 1'b1, 1'b1));
      send_event(book(255, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b1));
      send_event(book(255, 0, 32'hFFFF_FFFF, 1'b1, 1'b1));
      drain();

      // random traffic under each register setting
      for (int ph = 0; ph < 4; ph++) begin
         set_regs(regs[ph][0], regs[ph][1], regs[ph][2], regs[ph][3]);
         for (int i = 0; i < PHASE_EVENTS; i++) send_event(random_event());
         drain();
      end

      $display("covered %0d market events and %0d order requests over 5 register settings",
               events_seen, quotes_seen);
      if (errors == 0 && pending == 0) begin
         $display("[inventory_skewed_quote_engine] OK");
      end else begin
         $display("%0d mismatches, %0d requests never seen", errors, pending);
         $display("[inventory_skewed_quote_engine] ERROR");
      end
      $finish;
   end
endmodule
